FILE: sv/reefer_frame_parser_with_miss_count_unit_assert.svh
// Assertion macros shared by the frame parser RTL.
`ifndef REEFER_FRAME_PARSER_WITH_MISS_COUNT_UNIT_ASSERT_SVH
`define REEFER_FRAME_PARSER_WITH_MISS_COUNT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfp assertion failed");

`endif

FILE: sv/rfp_pkg.sv
// Shared types and constants for the reefer frame parser.
`default_nettype none
package rfp_pkg;

  localparam int unsigned FRAME_LENGTH = 8;
  localparam int unsigned DATA_LEN     = FRAME_LENGTH - 3;
  localparam int unsigned IDX_W        = $clog2(DATA_LEN);
  localparam int unsigned PHASE_W      = $clog2(FRAME_LENGTH);

  // Parse phases: hunt, second sync, data bytes, checksum.
  localparam logic [PHASE_W-1:0] PH_HUNT  = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PH_SYNC2 = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PH_DATA0 = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PH_CHECK = PHASE_W'(FRAME_LENGTH - 1);

  localparam logic REQ_BYTE   = 1'b0;
  localparam logic REQ_WAKE   = 1'b1;
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_WAKE  = 1'b1;

  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MISS_LIMIT  = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0] MISS_LIMIT_RST  = 8'd3;
  localparam logic [7:0] MISS_MAX        = 8'd255;

  typedef struct packed {
    logic        good;
    logic [15:0] setp;
    logic [15:0] act;
    logic [7:0]  status;
  } frame_t;

  typedef struct packed {
    logic [7:0]  missed_wakes;
    logic        commissioned;
    logic        readings_valid;
    logic [7:0]  status_byte;
    logic [15:0] actual_temp_tenths;
    logic [15:0] set_temp_tenths;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/rfp_parser.sv
// Sync hunt, payload capture and checksum check for incoming bytes.
`default_nettype none
module rfp_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_en,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [7:0]    sync_first,
  input  wire logic [7:0]    sync_second,
  output rfp_pkg::frame_t    frame
);

  logic [rfp_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [7:0]                  xor_r, xor_nxt;
  logic [7:0]                  store_r [rfp_pkg::DATA_LEN];
  logic [rfp_pkg::IDX_W-1:0]   idx;
  logic                        wr_en;
  logic                        good;

  assign idx = rfp_pkg::IDX_W'(phase_r - rfp_pkg::PH_DATA0);

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    wr_en     = 1'b0;
    good      = 1'b0;
    if (byte_en) begin
      case (phase_r)
        rfp_pkg::PH_HUNT: begin
          if (rx_byte == sync_first) phase_nxt = rfp_pkg::PH_SYNC2;
        end
        rfp_pkg::PH_SYNC2: begin
          // A wrong second byte may itself open a new frame.
          if (rx_byte == sync_second) begin
            phase_nxt = rfp_pkg::PH_DATA0;
            xor_nxt   = 8'd0;
          end else if (rx_byte != sync_first) begin
            phase_nxt = rfp_pkg::PH_HUNT;
          end
        end
        rfp_pkg::PH_CHECK: begin
          phase_nxt = rfp_pkg::PH_HUNT;
          good      = (rx_byte == xor_r);
        end
        default: begin
          wr_en     = 1'b1;
          xor_nxt   = xor_r ^ rx_byte;
          phase_nxt = phase_r + rfp_pkg::PHASE_W'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rfp_pkg::PH_HUNT;
      xor_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_r[idx] <= rx_byte;
  end

  assign frame.good   = good;
  assign frame.setp   = {store_r[0], store_r[1]};
  assign frame.act    = {store_r[2], store_r[3]};
  assign frame.status = store_r[4];

endmodule
`default_nettype wire

FILE: sv/rfp_status.sv
// Held readings, validity flags and missed wake counter; builds the result.
`default_nettype none
module rfp_status (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wake_en,
  input  wire rfp_pkg::frame_t frame,
  input  wire logic [7:0]    miss_limit,
  output rfp_pkg::result_t   res,
  output logic               res_vld
);

  logic [15:0] setp_r, setp_nxt;
  logic [15:0] act_r, act_nxt;
  logic [7:0]  stat_r, stat_nxt;
  logic        valid_r, valid_nxt;
  logic        seen_r, seen_nxt;
  logic        armed_r, armed_nxt;
  logic [7:0]  miss_r, miss_nxt;
  logic [7:0]  miss_inc;

  assign miss_inc = (miss_r == rfp_pkg::MISS_MAX) ? miss_r : miss_r + 8'd1;

  always_comb begin
    setp_nxt  = setp_r;
    act_nxt   = act_r;
    stat_nxt  = stat_r;
    valid_nxt = valid_r;
    seen_nxt  = seen_r;
    armed_nxt = armed_r;
    miss_nxt  = miss_r;
    if (wake_en) begin
      // A frame since the last wake clears the count instead of adding a miss.
      if (seen_r) begin
        miss_nxt = 8'd0;
        seen_nxt = 1'b0;
      end else begin
        miss_nxt = miss_inc;
        if (miss_inc >= miss_limit) valid_nxt = 1'b0;
      end
    end else if (frame.good) begin
      setp_nxt  = frame.setp;
      act_nxt   = frame.act;
      stat_nxt  = frame.status;
      valid_nxt = 1'b1;
      seen_nxt  = 1'b1;
      armed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setp_r  <= 16'd0;
      act_r   <= 16'd0;
      stat_r  <= 8'd0;
      valid_r <= 1'b0;
      seen_r  <= 1'b0;
      armed_r <= 1'b0;
      miss_r  <= 8'd0;
    end else begin
      setp_r  <= setp_nxt;
      act_r   <= act_nxt;
      stat_r  <= stat_nxt;
      valid_r <= valid_nxt;
      seen_r  <= seen_nxt;
      armed_r <= armed_nxt;
      miss_r  <= miss_nxt;
    end
  end

  assign res_vld                = wake_en || frame.good;
  assign res.set_temp_tenths    = valid_nxt ? setp_nxt : 16'd0;
  assign res.actual_temp_tenths = valid_nxt ? act_nxt : 16'd0;
  assign res.status_byte        = valid_nxt ? stat_nxt : 8'd0;
  assign res.readings_valid     = valid_nxt;
  assign res.commissioned       = armed_nxt;
  assign res.missed_wakes       = miss_nxt;

endmodule
`default_nettype wire

FILE: sv/reefer_frame_parser_with_miss_count_unit.sv
// An accepted request waits in the input register; its result, if any, is registered for out_*.
// Throughput: one request per cycle; a stalled result holds in the output register
// while one more request waits in the input register.
// Reset (rst_n low, synchronous): hunting for sync, flags and miss count cleared,
// sync bytes 0xAA and 0x55, miss limit 3. Payload bytes are not reset.
// Top level of the reefer frame parser with missed wake accounting.
`default_nettype none
`include "reefer_frame_parser_with_miss_count_unit_assert.svh"
module reefer_frame_parser_with_miss_count_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [15:0] set_temp_tenths, [31:16] actual_temp_tenths,
                                       // [39:32] status_byte, [40] readings_valid,
                                       // [41] commissioned, [49:42] missed_wakes, rest 0
  output logic             out_tuser   // [0] report_kind
);

  logic [7:0]       sync_first_r, sync_second_r, miss_limit_r;
  logic             in_vld_r, in_type_r;
  logic [7:0]       in_byte_r;
  logic             adv, step;
  logic             out_vld_r, out_kind_r;
  rfp_pkg::result_t out_res_r;
  rfp_pkg::frame_t  frame;
  rfp_pkg::result_t res;
  logic             res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= rfp_pkg::SYNC_FIRST_RST;
      sync_second_r <= rfp_pkg::SYNC_SECOND_RST;
      miss_limit_r  <= rfp_pkg::MISS_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rfp_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        rfp_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        rfp_pkg::CFG_MISS_LIMIT:  miss_limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The held request is processed whenever the result register can take its outcome.
  assign adv       = !out_vld_r || out_tready;
  assign step      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_type_r <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  rfp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (step && (in_type_r == rfp_pkg::REQ_BYTE)),
    .rx_byte     (in_byte_r),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .frame       (frame)
  );

  rfp_status u_status (
    .clk        (clk),
    .rst_n      (rst_n),
    .wake_en    (step && (in_type_r == rfp_pkg::REQ_WAKE)),
    .frame      (frame),
    .miss_limit (miss_limit_r),
    .res        (res),
    .res_vld    (res_vld)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= step && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_vld) begin
      out_res_r  <= res;
      out_kind_r <= (in_type_r == rfp_pkg::REQ_WAKE) ? rfp_pkg::KIND_WAKE
                                                     : rfp_pkg::KIND_FRAME;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'd0, out_res_r};

  `RFP_ASSERT_NOW(a_frame_sets_flags, clk, rst_n,
    out_vld_r && (out_kind_r == rfp_pkg::KIND_FRAME),
    out_res_r.readings_valid && out_res_r.commissioned)
  `RFP_ASSERT_NOW(a_invalid_zeroes, clk, rst_n,
    out_vld_r && !out_res_r.readings_valid,
    (out_res_r.set_temp_tenths == 16'd0) && (out_res_r.actual_temp_tenths == 16'd0)
      && (out_res_r.status_byte == 8'd0))
  `RFP_ASSERT_NEXT(a_accept_held, clk, rst_n, in_tvalid && in_tready, in_vld_r)
  `RFP_ASSERT_NOW(a_valid_needs_armed, clk, rst_n,
    out_vld_r && out_res_r.readings_valid, out_res_r.commissioned)

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the reefer frame parser with missed wake counting.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic             kind;
    rfp_pkg::result_t body;
  } report_item_t;

  // Tracks the parser state and queues the reports that each request should produce.
  class reefer_report_checker;
    logic [7:0]                  sync_first_r;
    logic [7:0]                  sync_second_r;
    logic [7:0]                  miss_limit_r;
    logic [rfp_pkg::PHASE_W-1:0] phase;
    logic [7:0]                  xor_acc;
    logic [7:0]                  payload [rfp_pkg::DATA_LEN];
    logic [15:0]                 setpoint;
    logic [15:0]                 actual;
    logic [7:0]                  status;
    logic                        readings_ok;
    logic                        seen;
    logic                        armed;
    logic [7:0]                  misses;
    report_item_t                awaited [$];
    int                          fault_count;
    int                          frames_ok;
    int                          wake_reports;

    function new();
      reset_state();
      fault_count  = 0;
      frames_ok    = 0;
      wake_reports = 0;
    endfunction

    function void reset_state();
      sync_first_r  = rfp_pkg::SYNC_FIRST_RST;
      sync_second_r = rfp_pkg::SYNC_SECOND_RST;
      miss_limit_r  = rfp_pkg::MISS_LIMIT_RST;
      phase         = rfp_pkg::PH_HUNT;
      xor_acc       = 8'h00;
      setpoint      = 16'h0000;
      actual        = 16'h0000;
      status        = 8'h00;
      readings_ok   = 1'b0;
      seen          = 1'b0;
      armed         = 1'b0;
      misses        = 8'h00;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        rfp_pkg::CFG_SYNC_FIRST:  sync_first_r  = value;
        rfp_pkg::CFG_SYNC_SECOND: sync_second_r = value;
        rfp_pkg::CFG_MISS_LIMIT:  miss_limit_r  = value;
        default: ;
      endcase
    endfunction

    function void queue_report(logic kind);
      report_item_t item;
      item.kind                    = kind;
      // Held readings are kept but reported as zero while invalid.
      item.body.set_temp_tenths    = readings_ok ? setpoint : 16'h0000;
      item.body.actual_temp_tenths = readings_ok ? actual : 16'h0000;
      item.body.status_byte        = readings_ok ? status : 8'h00;
      item.body.readings_valid     = readings_ok;
      item.body.commissioned       = armed;
      item.body.missed_wakes       = misses;
      awaited.push_back(item);
    endfunction

    function void note_request(logic req, logic [7:0] b);
      if (req == rfp_pkg::REQ_WAKE) begin
        if (seen) begin
          misses = 8'h00;
          seen   = 1'b0;
        end else begin
          if (misses != rfp_pkg::MISS_MAX) misses++;
          if (misses >= miss_limit_r) readings_ok = 1'b0;
        end
        wake_reports++;
        queue_report(rfp_pkg::KIND_WAKE);
        return;
      end
      case (phase)
        rfp_pkg::PH_HUNT: begin
          if (b == sync_first_r) phase = rfp_pkg::PH_SYNC2;
        end
        rfp_pkg::PH_SYNC2: begin
          // A wrong second byte may itself start a new frame.
          if (b == sync_second_r) begin
            phase   = rfp_pkg::PH_DATA0;
            xor_acc = 8'h00;
          end else if (b != sync_first_r) begin
            phase = rfp_pkg::PH_HUNT;
          end
        end
        default: begin
          if (phase < rfp_pkg::PH_CHECK) begin
            payload[phase - rfp_pkg::PH_DATA0] = b;
            xor_acc ^= b;
            phase++;
          end else begin
            phase = rfp_pkg::PH_HUNT;
            if (b == xor_acc) begin
              setpoint    = {payload[0], payload[1]};
              actual      = {payload[2], payload[3]};
              status      = payload[4];
              readings_ok = 1'b1;
              seen        = 1'b1;
              armed       = 1'b1;
              frames_ok++;
              queue_report(rfp_pkg::KIND_FRAME);
            end
          end
        end
      endcase
    endfunction

    task report_fault(string msg);
      fault_count++;
      if (fault_count <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [15:0] got_v, logic [15:0] want_v);
      if (got_v !== want_v)
        report_fault($sformatf("%s got 0x%0h, expected 0x%0h", name, got_v, want_v));
    endtask

    task check_report(logic [55:0] data, logic kind);
      report_item_t     want;
      rfp_pkg::result_t got;
      if (awaited.size() == 0) begin
        report_fault($sformatf("result of kind %0d with nothing expected", kind));
        return;
      end
      want = awaited.pop_front();
      got  = rfp_pkg::result_t'(data[49:0]);
      compare_field("report_kind", 16'(kind), 16'(want.kind));
      compare_field("set_temp_tenths", got.set_temp_tenths, want.body.set_temp_tenths);
      compare_field("actual_temp_tenths", got.actual_temp_tenths,
                    want.body.actual_temp_tenths);
      compare_field("status_byte", 16'(got.status_byte), 16'(want.body.status_byte));
      compare_field("readings_valid", 16'(got.readings_valid),
                    16'(want.body.readings_valid));
      compare_field("commissioned", 16'(got.commissioned), 16'(want.body.commissioned));
      compare_field("missed_wakes", 16'(got.missed_wakes), 16'(want.body.missed_wakes));
      compare_field("tdata padding", 16'(data[55:50]), 16'h0000);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        in_tuser;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // [15:0] set, [31:16] actual, [39:32] status, [40] valid,
                           // [41] commissioned, [49:42] missed_wakes
  logic        out_tuser;  // [0] report_kind

  reefer_report_checker chk = new();

  int         tx_gap_max = 10;
  int         rx_gap_max = 10;
  int         rx_hold    = 0;
  int         wake_mid_pct = 0;
  int         sent_count = 0;
  int         phase_count = 0;
  logic [7:0] cur_first  = rfp_pkg::SYNC_FIRST_RST;
  logic [7:0] cur_second = rfp_pkg::SYNC_SECOND_RST;

  reefer_frame_parser_with_miss_count_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) chk.check_report(out_tdata, out_tuser);
  end

  // Result side: random stalls before each result, plus one long hold-off on demand.
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, rx_gap_max);
      if (rx_hold != 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_item(logic req, logic [7:0] b);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= b;
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    chk.note_request(req, b);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(rfp_pkg::REQ_BYTE, b);
  endtask

  task automatic send_wake();
    send_item(rfp_pkg::REQ_WAKE, 8'($urandom));
  endtask

  task automatic send_frame(logic [15:0] setp, logic [15:0] act, logic [7:0] stat,
                            bit good, int wake_at);
    logic [7:0] frame_bytes [8];
    logic [7:0] sum;
    sum = setp[15:8] ^ setp[7:0] ^ act[15:8] ^ act[7:0] ^ stat;
    if (!good) sum ^= 8'h01 << $urandom_range(0, 7);
    frame_bytes = '{cur_first, cur_second, setp[15:8], setp[7:0],
                    act[15:8], act[7:0], stat, sum};
    for (int i = 0; i < 8; i++) begin
      if (i == wake_at || $urandom_range(0, 99) < wake_mid_pct) send_wake();
      send_byte(frame_bytes[i]);
    end
  endtask

  function automatic logic [15:0] rand_temp();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      send_frame(rand_temp(), rand_temp(), 8'($urandom), $urandom_range(0, 3) != 0, -1);
    end else if (pick < 80) begin
      send_wake();
    end else if (pick < 90) begin
      send_byte(8'($urandom));
    end else begin
      // Broken start: first sync followed by an arbitrary byte.
      send_byte(cur_first);
      send_byte(8'($urandom));
    end
  endtask

  // Only write registers once everything in flight has drained out of the block.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (chk.awaited.size() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_registers(logic [7:0] first, logic [7:0] second, logic [7:0] limit,
                               bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= rfp_pkg::CFG_SYNC_FIRST;
    cfg_wdata <= first;
    chk.write_reg(rfp_pkg::CFG_SYNC_FIRST, first);
    @(negedge clk);
    cfg_index <= rfp_pkg::CFG_SYNC_SECOND;
    cfg_wdata <= second;
    chk.write_reg(rfp_pkg::CFG_SYNC_SECOND, second);
    @(negedge clk);
    cfg_index <= rfp_pkg::CFG_MISS_LIMIT;
    cfg_wdata <= limit;
    chk.write_reg(rfp_pkg::CFG_MISS_LIMIT, limit);
    @(negedge clk);
    if (poke_unused) begin
      // Writes to the spare index must leave every register alone.
      cfg_index <= CFG_UNUSED;
      cfg_wdata <= 8'($urandom);
      chk.write_reg(CFG_UNUSED, cfg_wdata);
      @(negedge clk);
    end
    cfg_we     <= 1'b0;
    cur_first  = first;
    cur_second = second;
    phase_count++;
  endtask

  initial begin
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] limit;
    int         phase_start;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = rfp_pkg::CFG_SYNC_FIRST;
    cfg_wdata = 8'h00;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = rfp_pkg::REQ_BYTE;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings, extremes, re-examined sync, mid-frame wake, miss limit.
    send_wake();
    send_byte(rfp_pkg::SYNC_FIRST_RST);
    send_frame(16'h8000, 16'h7FFF, 8'hFF, 1'b1, 3);
    send_wake();
    repeat (3) send_wake();
    send_frame(16'h7FFF, 16'h8000, 8'h00, 1'b0, -1);

    for (int p = 0; p < 9; p++) begin
      drain();
      case (p)
        0: begin
          first  = 8'h00;
          second = 8'hFF;
          limit  = 8'd0;
        end
        1: begin
          first  = 8'hFF;
          second = 8'h00;
          limit  = 8'd255;
        end
        2: begin
          first  = 8'($urandom);
          second = first;
          limit  = 8'd1;
        end
        default: begin
          first  = 8'($urandom);
          second = ($urandom_range(0, 4) == 0) ? first : 8'($urandom);
          limit  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(1, 5));
        end
      endcase
      set_registers(first, second, limit, p == 0);
      tx_gap_max   = (p == 3) ? 0 : 10;
      rx_gap_max   = (p == 3) ? 0 : 10;
      wake_mid_pct = 3;
      if (p == 1) begin
        // Long run of missed wakes to push the counter into saturation.
        send_frame(rand_temp(), rand_temp(), 8'($urandom), 1'b1, -1);
        repeat (260) send_wake();
      end
      if (p == 5) begin
        rx_hold    = 300;
        tx_gap_max = 0;
        repeat (40) send_wake();
        tx_gap_max = 10;
      end
      phase_start = sent_count;
      while (sent_count - phase_start < 175) random_request();
    end

    drain();
    $display("run covered %0d requests over %0d register settings", sent_count,
             phase_count);
    $display("checked %0d accepted frames and %0d wake reports, %0d mismatches",
             chk.frames_ok, chk.wake_reports, chk.fault_count);
    if (chk.fault_count == 0 && chk.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/rfp_pkg.sv
sv/rfp_parser.sv
sv/rfp_status.sv
sv/reefer_frame_parser_with_miss_count_unit.sv
tb/testbench.sv
